### src/ird_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the input-restricted deque.
// Used by every module of the block and by its checker; no dependencies.
package ird_pkg;

	localparam int DEPTH_DEF  = 64;
	localparam int DATA_W     = 32;

	localparam logic [1:0] KIND_PUSH      = 2'd0;
	localparam logic [1:0] KIND_POP_FRONT = 2'd1;
	localparam logic [1:0] KIND_POP_REAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [DATA_W-1:0] push_value;
	} req_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pop_value;
		logic [1:0]               status;
		logic                     is_empty;
		logic                     is_full;
	} rsp_item_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic exec;
	} ird_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEND = 2'b10
	} ird_state_t;

endpackage

### src/ird_ctrl.sv
`timescale 1ns / 1ps
// Controller of the input-restricted deque: handshakes and sequencing.
// Depends on ird_pkg.
module ird_ctrl
	import ird_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ird_cmd_t cmd
);

	ird_state_t state_q;
	ird_state_t state_d;

	// A new request may enter in the same cycle that the pending response leaves.
	assign req_stall = (state_q == ST_SEND) && rsp_stall;
	assign rsp_valid = (state_q == ST_SEND);
	assign cmd.exec  = req_valid && !req_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.exec) state_d = ST_SEND;
			end
			ST_SEND: begin
				if (!rsp_stall) state_d = cmd.exec ? ST_SEND : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/ird_datapath.sv
`timescale 1ns / 1ps
// Datapath of the input-restricted deque: entry memory, pointers, count
// and the response register. Depends on ird_pkg.
module ird_datapath
	import ird_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ird_cmd_t  cmd,
	input  req_item_t req,
	output rsp_item_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_next, tail_next, tail_prev;
	logic [AW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d;
	logic          is_empty, is_full;
	logic          do_push, do_pop_front, do_pop_rear;
	logic [1:0]    status_d;

	logic signed [DATA_W-1:0] rdata_q;
	logic                     pop_ok_q;
	logic [1:0]               status_q;
	logic                     empty_q, full_q;

	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == FULL_CNT);
	assign head_next = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST : tail_q - 1'b1;

	always_comb begin
		do_push      = 1'b0;
		do_pop_front = 1'b0;
		do_pop_rear  = 1'b0;
		status_d     = ST_OK;
		case (req.kind)
			KIND_PUSH: begin
				if (is_full) status_d = ST_FULL;
				else do_push = 1'b1;
			end
			KIND_POP_FRONT: begin
				if (is_empty) status_d = ST_EMPTY;
				else do_pop_front = 1'b1;
			end
			KIND_POP_REAR: begin
				if (is_empty) status_d = ST_EMPTY;
				else do_pop_rear = 1'b1;
			end
			default: status_d = ST_OK;
		endcase
	end

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		if (do_push) begin
			tail_d  = tail_next;
			count_d = count_q + 1'b1;
		end else if (do_pop_front) begin
			head_d  = head_next;
			count_d = count_q - 1'b1;
		end else if (do_pop_rear) begin
			tail_d  = tail_prev;
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// Entry memory with a registered read port; the read data is held
	// until the next transaction, which keeps the response stable.
	always_ff @(posedge clk) begin
		if (cmd.exec && do_push) mem[tail_q] <= req.push_value;
		if (cmd.exec) rdata_q <= mem[do_pop_rear ? tail_prev : head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pop_ok_q <= do_pop_front || do_pop_rear;
			status_q <= status_d;
			empty_q  <= (count_d == '0);
			full_q   <= (count_d == FULL_CNT);
		end
	end

	assign rsp.pop_value = pop_ok_q ? rdata_q : '0;
	assign rsp.status    = status_q;
	assign rsp.is_empty  = empty_q;
	assign rsp.is_full   = full_q;

endmodule

### src/input_restricted_deque.sv
`timescale 1ns / 1ps
// Input-restricted deque: a circular buffer of DEPTH signed 32-bit entries
// that takes pushes at the rear and pops from either end. Every request
// yields exactly one response in the cycle after it is accepted, carrying the
// popped value (0 when nothing is popped), a status code and the empty and
// full flags as they stand after the request. One request per cycle is
// sustained while the response is not stalled: the response register
// frees in the cycle it is taken, so a new request may enter in that same
// cycle, and the read of the entry memory is registered with the response.
// The memory needs no clearing after reset; pops only read entries that
// were pushed. Depends on ird_pkg, ird_ctrl and ird_datapath.
module input_restricted_deque
	import ird_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	ird_cmd_t cmd;

	ird_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	ird_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

### src/ird_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the input-restricted deque, bound to the top level.
// Depends on ird_pkg and input_restricted_deque.
module ird_checker
	import ird_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp
);

	// A stalled response holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Every accepted request has its response on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("response missing after accepted request");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.is_empty && rsp.is_full))
		else $error("queue flagged both empty and full");

	// A refused pop leaves the queue empty and returns zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.is_empty && rsp.pop_value == '0)
		else $error("refused pop with inconsistent response");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.is_full && rsp.pop_value == '0)
		else $error("refused push with inconsistent response");

endmodule

bind input_restricted_deque ird_checker u_ird_checker (.*);

### verif/input_restricted_deque_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the input-restricted deque: directed corner rows, then random
// fill, drain and mixed traffic with random idling on both channels. Depends on ird_pkg.
module input_restricted_deque_tb;
	import ird_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PCT       = 21;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef enum int {FILL_HEAVY, DRAIN_HEAVY, BALANCED} traffic_t;

	typedef struct {
		req_item_t req;
		bit        typed;
		rsp_item_t rsp;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// Predicted deque contents and pointers.
	logic signed [DATA_W-1:0] slots [DEPTH];
	int unsigned front_slot = 0;
	int unsigned rear_slot  = 0;
	int unsigned held       = 0;

	rsp_item_t queued_rsps [$];
	bit        no_idle     = 1'b0;
	int        errors      = 0;
	int        checked     = 0;
	int        idle_cycles = 0;
	int        pushes = 0, pops = 0, full_refusals = 0, empty_refusals = 0, noops = 0;

	// Rows with a typed response are read straight off the spec; the rest use the predictor.
	stim_row_t directed_rows [20] = '{
		'{'{KIND_POP_FRONT, 32'sh00000000}, 1'b1, '{32'sh00000000, ST_EMPTY, 1'b1, 1'b0}},
		'{'{KIND_POP_REAR,  32'shFFFFFFFF}, 1'b1, '{32'sh00000000, ST_EMPTY, 1'b1, 1'b0}},
		'{'{KIND_UNUSED,    32'shFFFFFFFF}, 1'b1, '{32'sh00000000, ST_OK,    1'b1, 1'b0}},
		'{'{KIND_PUSH,      32'sh7FFFFFFF}, 1'b1, '{32'sh00000000, ST_OK,    1'b0, 1'b0}},
		'{'{KIND_PUSH,      32'sh80000000}, 1'b1, '{32'sh00000000, ST_OK,    1'b0, 1'b0}},
		'{'{KIND_POP_REAR,  32'sh12345678}, 1'b1, '{32'sh80000000, ST_OK,    1'b0, 1'b0}},
		'{'{KIND_POP_FRONT, 32'shFFFFFFFF}, 1'b1, '{32'sh7FFFFFFF, ST_OK,    1'b1, 1'b0}},
		'{'{KIND_POP_REAR,  32'sh00000000}, 1'b1, '{32'sh00000000, ST_EMPTY, 1'b1, 1'b0}},
		'{'{KIND_PUSH,      32'sh00000000}, 1'b1, '{32'sh00000000, ST_OK,    1'b0, 1'b0}},
		'{'{KIND_PUSH,      32'shFFFFFFFF}, 1'b1, '{32'sh00000000, ST_OK,    1'b0, 1'b0}},
		'{'{KIND_PUSH,      32'sh55555555}, 1'b0, '0},
		'{'{KIND_PUSH,      32'shAAAAAAAA}, 1'b0, '0},
		'{'{KIND_UNUSED,    32'sh00000000}, 1'b0, '0},
		'{'{KIND_POP_FRONT, 32'sh00000000}, 1'b0, '0},
		'{'{KIND_POP_REAR,  32'sh00000000}, 1'b0, '0},
		'{'{KIND_PUSH,      32'sh00000001}, 1'b0, '0},
		'{'{KIND_POP_FRONT, 32'sh00000000}, 1'b0, '0},
		'{'{KIND_POP_FRONT, 32'sh00000000}, 1'b0, '0},
		'{'{KIND_POP_REAR,  32'sh00000000}, 1'b0, '0},
		'{'{KIND_POP_FRONT, 32'sh00000000}, 1'b1, '{32'sh00000000, ST_EMPTY, 1'b1, 1'b0}}
	};

	input_restricted_deque #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	function automatic rsp_item_t apply_request(req_item_t r);
		rsp_item_t o;
		o = '0;
		o.status = ST_OK;
		case (r.kind)
			KIND_PUSH: begin
				if (held == DEPTH) begin
					o.status = ST_FULL;
				end else begin
					slots[rear_slot] = r.push_value;
					rear_slot = (rear_slot + 1) % DEPTH;
					held++;
				end
			end
			KIND_POP_FRONT: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.pop_value = slots[front_slot];
					front_slot = (front_slot + 1) % DEPTH;
					held--;
				end
			end
			KIND_POP_REAR: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					rear_slot = (rear_slot + DEPTH - 1) % DEPTH;
					o.pop_value = slots[rear_slot];
					held--;
				end
			end
			default: begin
			end
		endcase
		o.is_empty = (held == 0);
		o.is_full  = (held == DEPTH);
		return o;
	endfunction

	function automatic req_item_t random_request(traffic_t mode);
		req_item_t r;
		int unsigned pick;
		int unsigned push_pct;
		pick = $urandom_range(99);
		push_pct = (mode == FILL_HEAVY) ? 85 : (mode == DRAIN_HEAVY) ? 18 : 50;
		r.push_value = $urandom;
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: r.push_value = 32'sh7FFFFFFF;
				1: r.push_value = 32'sh80000000;
				2: r.push_value = 32'sh00000000;
				default: r.push_value = 32'shFFFFFFFF;
			endcase
		end
		if (pick < 4)
			r.kind = KIND_UNUSED;
		else if (pick < push_pct)
			r.kind = KIND_PUSH;
		else
			r.kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_REAR;
		return r;
	endfunction

	// Presents one request, holds it until accepted and records the response it must produce.
	task automatic send_request(input req_item_t item, input bit typed, input rsp_item_t typed_rsp);
		rsp_item_t predicted;
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		predicted = apply_request(item);
		queued_rsps.push_back(typed ? typed_rsp : predicted);
		if (item.kind == KIND_UNUSED)
			noops++;
		else if (predicted.status == ST_FULL)
			full_refusals++;
		else if (predicted.status == ST_EMPTY)
			empty_refusals++;
		else if (item.kind == KIND_PUSH)
			pushes++;
		else
			pops++;
	endtask

	task automatic wait_for_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (queued_rsps.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_response(input rsp_item_t got);
		rsp_item_t want;
		if (queued_rsps.size() == 0) begin
			$display("%0t: response with no request pending: %p", $time, got);
			errors++;
		end else begin
			want = queued_rsps.pop_front();
			checked++;
			if (got.pop_value !== want.pop_value) begin
				$display("%0t: pop_value expected %0d actual %0d", $time, want.pop_value,
					got.pop_value);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty,
					got.is_empty);
				errors++;
			end
			if (got.is_full !== want.is_full) begin
				$display("%0t: is_full expected %0b actual %0b", $time, want.is_full,
					got.is_full);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			check_response(rsp);
		rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[input_restricted_deque] ERROR");
			$finish;
		end
	end

	initial begin
		int made;
		int phase_no;
		int phase_len;
		traffic_t mode;
		req_item_t item;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
		wait_for_responses();

		// Fill-heavy and drain-heavy phases push the deque against both walls many times.
		made = 0;
		phase_no = 0;
		while (made < RANDOM_ITEMS) begin
			mode = traffic_t'(phase_no % 3);
			phase_len = $urandom_range(140, 60);
			no_idle = (phase_no == 3);
			repeat (phase_len) begin
				item = random_request(mode);
				send_request(item, 1'b0, '0);
				if (item.kind != KIND_UNUSED)
					made++;
			end
			if (phase_no == 4)
				wait_for_responses();
			phase_no++;
		end
		no_idle = 1'b0;

		wait_for_responses();
		repeat (8) @(posedge clk);
		$display("Covered %0d pushes, %0d pops, %0d refused as full, %0d refused as empty,",
			pushes, pops, full_refusals, empty_refusals);
		$display("%0d no-op requests; %0d responses checked, %0d mismatches.",
			noops, checked, errors);
		if (errors == 0 && queued_rsps.size() == 0)
			$display("[input_restricted_deque] OK");
		else
			$display("[input_restricted_deque] ERROR");
		$finish;
	end

endmodule

### filelist.f
src/ird_pkg.sv
src/ird_ctrl.sv
src/ird_datapath.sv
src/input_restricted_deque.sv
src/ird_checker.sv
verif/input_restricted_deque_tb.sv
